FILE: rtl/tkri_pkg.sv
`default_nettype none
package tkri_pkg;

	localparam int DEPTH   = 16;
	localparam int MAX_OUT = 16;
	localparam int SCORE_W = 32;
	localparam int KEY_W   = 16;
	localparam int RANK_W  = 4;
	localparam int METRIC_W  = 2;
	localparam int ENTRIES_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 5;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [ENTRIES_W-1:0] ENTRIES_RST = ENTRIES_W'(16);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_METRIC  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 1'b1;

	// opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DUMP   = 1'b1;

	// metric codes
	localparam logic [METRIC_W-1:0] MET_LOGINS = 2'd0;
	localparam logic [METRIC_W-1:0] MET_POSTS  = 2'd1;
	localparam logic [METRIC_W-1:0] MET_STAY   = 2'd2;
	localparam logic [METRIC_W-1:0] MET_MERIT  = 2'd3;

	typedef enum logic {
		DS_IDLE,
		DS_SEND
	} dump_state_t;

	// what one cell hands to the next one down
	typedef struct packed {
		logic               found;
		logic [SCORE_W-1:0] score;
		logic [KEY_W-1:0]   key;
	} link_t;

	// candidate broadcast to every cell
	typedef struct packed {
		logic               ins;
		logic [SCORE_W-1:0] score;
		logic [KEY_W-1:0]   key;
	} cand_t;

endpackage
`default_nettype wire

FILE: rtl/tkri_cell.sv
`default_nettype none
module tkri_cell
	import tkri_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  active,
	input  wire cand_t cand,
	input  wire link_t link_i,
	output link_t      link_o
);

	logic [SCORE_W-1:0] score_q;
	logic [KEY_W-1:0]   key_q;
	logic               lt;

	assign lt = active && (score_q < cand.score);

	assign link_o.found = link_i.found | lt;
	assign link_o.score = score_q;
	assign link_o.key   = key_q;

	// an upper place already took the candidate: shift down; else take it if smaller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
			key_q   <= '0;
		end else if (cand.ins && active) begin
			if (link_i.found) begin
				score_q <= link_i.score;
				key_q   <= link_i.key;
			end else if (lt) begin
				score_q <= cand.score;
				key_q   <= cand.key;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/tkri_dump.sv
`default_nettype none
module tkri_dump
	import tkri_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [CNT_W-1:0]              dump_n,
	input  wire logic [DEPTH-1:0][SCORE_W-1:0] scores,
	input  wire logic [DEPTH-1:0][KEY_W-1:0]   keys,
	output logic                               busy,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [RANK_W-1:0]                  rank,
	output logic [KEY_W-1:0]                   ranked_key,
	output logic [SCORE_W-1:0]                 ranked_score,
	output logic                               last
);

	dump_state_t        state_q, state_nxt;
	logic [IDX_W-1:0]   idx_q;
	logic               out_valid_q;
	logic               load;
	logic               at_end;

	assign at_end = (CNT_W'(idx_q) + CNT_W'(1)) == dump_n;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			DS_IDLE: if (start) state_nxt = DS_SEND;
			DS_SEND: if (load && at_end) state_nxt = DS_IDLE;
			default: state_nxt = DS_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b0;
		load = 1'b0;
		case (state_q)
			DS_IDLE: ;
			DS_SEND: begin
				busy = 1'b1;
				load = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DS_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (start) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register, payload only
	always_ff @(posedge clk) begin
		if (load) begin
			rank         <= RANK_W'(idx_q);
			ranked_key   <= keys[idx_q];
			ranked_score <= scores[idx_q];
			last         <= at_end;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/top_k_ranking_insert_core.sv
`default_nettype none
// Top-K ranking list, DEPTH places in a systolic chain of compare/shift cells.
// Insert: accepted every cycle unless a dump is busy; all places compare and shift together.
// Dump: emits min(places kept, 16) results via state and output registers, one per
//   cycle while out_stall is low; input is stalled until the final result is registered.
// Reset (arst_n low, async) clears all places to zero, metric to logins, places to 16.
module top_k_ranking_insert_core
	import tkri_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	// input items
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 op,
	input  wire logic [KEY_W-1:0]     key,
	input  wire logic [SCORE_W-1:0]   logins,
	input  wire logic [SCORE_W-1:0]   posts,
	input  wire logic [SCORE_W-1:0]   stay_seconds,
	input  wire logic [SCORE_W-1:0]   merit,
	// result items
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [RANK_W-1:0]         rank,
	output logic [KEY_W-1:0]          ranked_key,
	output logic [SCORE_W-1:0]        ranked_score,
	output logic                      last
);

	logic [METRIC_W-1:0]  metric_q;
	logic [ENTRIES_W-1:0] entries_q;

	logic [CNT_W-1:0]     kept;
	logic [CNT_W-1:0]     dump_n;
	logic                 in_acc;
	logic                 busy;
	cand_t                cand;

	link_t                     links [DEPTH+1];
	logic [DEPTH-1:0][SCORE_W-1:0] scores;
	logic [DEPTH-1:0][KEY_W-1:0]   keys;

	// config registers; the user writes them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q  <= MET_LOGINS;
			entries_q <= ENTRIES_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_METRIC:  metric_q  <= cfg_data[METRIC_W-1:0];
				REG_ENTRIES: entries_q <= cfg_data[ENTRIES_W-1:0];
				default: ;
			endcase
		end
	end

	// place count clamps at DEPTH; a dump also clamps at the rank range
	always_comb begin
		if (32'(entries_q) > 32'(DEPTH)) begin
			kept = CNT_W'(DEPTH);
		end else begin
			kept = CNT_W'(entries_q);
		end
		if (32'(kept) > 32'(MAX_OUT)) begin
			dump_n = CNT_W'(MAX_OUT);
		end else begin
			dump_n = kept;
		end
	end

	assign in_stall = busy;
	assign in_acc   = in_valid && !in_stall;

	// score selection, broadcast down the chain
	always_comb begin
		cand.ins = in_acc && (op == OP_INSERT);
		cand.key = key;
		case (metric_q)
			MET_LOGINS: cand.score = logins;
			MET_POSTS:  cand.score = posts;
			MET_STAY:   cand.score = stay_seconds;
			MET_MERIT:  cand.score = merit;
			default:    cand.score = merit;
		endcase
	end

	// head of chain: nothing found above place 0
	assign links[0] = '{found: 1'b0, score: '0, key: '0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		tkri_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.active (32'(i) < 32'(kept)),
			.cand   (cand),
			.link_i (links[i]),
			.link_o (links[i+1])
		);
		assign scores[i] = links[i+1].score;
		assign keys[i]   = links[i+1].key;
	end

	// dump sequencer with output register; zero places means no results
	tkri_dump u_dump (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_acc && (op == OP_DUMP) && (dump_n != '0)),
		.dump_n       (dump_n),
		.scores       (scores),
		.keys         (keys),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.rank         (rank),
		.ranked_key   (ranked_key),
		.ranked_score (ranked_score),
		.last         (last)
	);

endmodule
`default_nettype wire

FILE: tb/top_k_ranking_insert_core_tb.sv
`default_nettype none
// Self-checking bench for the top-K ranking insert core.
// A directed table runs first (empty list after reset, zero scores, ties, every
// metric, place counts of one, zero and above the depth), then random blocks under
// changing register settings and three idling patterns on the two item channels.
module top_k_ranking_insert_core_tb;
	import tkri_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int BLOCKS      = 9;
	localparam int BLOCK_ITEMS = 43;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_REG,
		ROW_KNOWN_DUMP
	} row_kind_t;

	// one stimulus line: a register write, an item, or a dump whose listing is typed in
	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [CFG_DAT_W-1:0]   reg_val;
		logic                   op;
		logic [KEY_W-1:0]       key;
		logic [SCORE_W-1:0]     logins;
		logic [SCORE_W-1:0]     posts;
		logic [SCORE_W-1:0]     stay;
		logic [SCORE_W-1:0]     merit;
		logic [KEY_W-1:0]       top_key;
		logic [SCORE_W-1:0]     top_score;
	} row_t;

	// one line of a dump listing
	typedef struct {
		logic [RANK_W-1:0]  rank;
		logic [KEY_W-1:0]   key;
		logic [SCORE_W-1:0] score;
		logic               last;
	} place_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 op;
	logic [KEY_W-1:0]     key;
	logic [SCORE_W-1:0]   logins;
	logic [SCORE_W-1:0]   posts;
	logic [SCORE_W-1:0]   stay_seconds;
	logic [SCORE_W-1:0]   merit;
	logic                 out_valid;
	logic                 out_stall;
	logic [RANK_W-1:0]    rank;
	logic [KEY_W-1:0]     ranked_key;
	logic [SCORE_W-1:0]   ranked_score;
	logic                 last;

	// travels with the payload: the current dump has a typed-in listing
	logic                 known_now;
	logic [KEY_W-1:0]     known_key;
	logic [SCORE_W-1:0]   known_score;

	// bench copy of the ranked list and the registers
	logic [SCORE_W-1:0]   score_tab [DEPTH];
	logic [KEY_W-1:0]     key_tab [DEPTH];
	logic [METRIC_W-1:0]  metric_now;
	logic [ENTRIES_W-1:0] places_now;

	place_t listing_q[$];
	row_t   plan[$];
	int     fails;
	int     cycles;
	int     send_pct;
	int     recv_pct;

	top_k_ranking_insert_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.key          (key),
		.logins       (logins),
		.posts        (posts),
		.stay_seconds (stay_seconds),
		.merit        (merit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.rank         (rank),
		.ranked_key   (ranked_key),
		.ranked_score (ranked_score),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// places that take part in compare, shift and dump
	function automatic int kept_count();
		return (int'(places_now) > DEPTH) ? DEPTH : int'(places_now);
	endfunction

	function automatic logic [SCORE_W-1:0] score_of(logic [SCORE_W-1:0] lg,
			logic [SCORE_W-1:0] ps, logic [SCORE_W-1:0] st, logic [SCORE_W-1:0] mr);
		case (metric_now)
			MET_LOGINS: return lg;
			MET_POSTS:  return ps;
			MET_STAY:   return st;
			default:    return mr;
		endcase
	endfunction

	// goes in ahead of the first strictly smaller score, so ties keep arrival order;
	// places past the kept count are left alone
	function automatic void rank_insert(logic [KEY_W-1:0] k, logic [SCORE_W-1:0] s);
		int n;
		n = kept_count();
		for (int i = 0; i < n; i++) begin
			if (score_tab[i] < s) begin
				for (int j = n - 1; j > i; j--) begin
					score_tab[j] = score_tab[j-1];
					key_tab[j]   = key_tab[j-1];
				end
				score_tab[i] = s;
				key_tab[i]   = k;
				return;
			end
		end
	endfunction

	function automatic void list_places();
		int     n;
		place_t p;
		n = kept_count();
		if (n > MAX_OUT)
			n = MAX_OUT;
		for (int i = 0; i < n; i++) begin
			p.rank  = RANK_W'(i);
			p.key   = key_tab[i];
			p.score = score_tab[i];
			p.last  = (i == n - 1);
			listing_q.push_back(p);
		end
	endfunction

	// --------------------------------------------------- prediction and checking
	// Inputs, register writes and results are all sampled at the same edge in one
	// process, so the expectation for a dump is queued before any of its results.
	always @(posedge clk) begin
		place_t want;
		if (arst_n) begin
			if (cfg_write) begin
				if (cfg_index == REG_METRIC)
					metric_now = cfg_data[METRIC_W-1:0];
				else
					places_now = cfg_data[ENTRIES_W-1:0];
			end
			if (in_valid && !in_stall) begin
				if (op == OP_INSERT) begin
					rank_insert(key, score_of(logins, posts, stay_seconds, merit));
				end else if (known_now) begin
					// typed-in listing: the top place as given, the rest empty
					for (int i = 0; i < MAX_OUT; i++) begin
						want.rank  = RANK_W'(i);
						want.key   = (i == 0) ? known_key : '0;
						want.score = (i == 0) ? known_score : '0;
						want.last  = (i == MAX_OUT - 1);
						listing_q.push_back(want);
					end
				end else begin
					list_places();
				end
			end
			if (out_valid && !out_stall) begin
				if (listing_q.size() == 0) begin
					$error("result with nothing expected: rank %0d key %0h score %0h",
						rank, ranked_key, ranked_score);
					fails++;
				end else begin
					want = listing_q.pop_front();
					if (rank !== want.rank) begin
						$error("rank: expected %0d, got %0d", want.rank, rank);
						fails++;
					end
					if (ranked_key !== want.key) begin
						$error("ranked_key: expected %0h, got %0h", want.key, ranked_key);
						fails++;
					end
					if (ranked_score !== want.score) begin
						$error("ranked_score: expected %0h, got %0h", want.score, ranked_score);
						fails++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						fails++;
					end
				end
			end
		end
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ----------------------------------------------------------------- stimulus

	function automatic row_t item_row(logic o, logic [KEY_W-1:0] k, logic [SCORE_W-1:0] lg,
			logic [SCORE_W-1:0] ps, logic [SCORE_W-1:0] st, logic [SCORE_W-1:0] mr);
		row_t r;
		r.kind   = ROW_ITEM;
		r.op     = o;
		r.key    = k;
		r.logins = lg;
		r.posts  = ps;
		r.stay   = st;
		r.merit  = mr;
		return r;
	endfunction

	function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		row_t r;
		r = item_row(OP_INSERT, '0, '0, '0, '0, '0);
		r.kind    = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic row_t known_dump(logic [KEY_W-1:0] k, logic [SCORE_W-1:0] s);
		row_t r;
		r = item_row(OP_DUMP, '0, '0, '0, '0, '0);
		r.kind      = ROW_KNOWN_DUMP;
		r.top_key   = k;
		r.top_score = s;
		return r;
	endfunction

	// random candidate; up to half of the scores land next to a score already held, so inserts
	// keep hitting the middle of the list and produce ties
	function automatic row_t draw_candidate();
		row_t               r;
		logic [SCORE_W-1:0] s;
		int                 pick;
		int                 n;
		r = item_row(($urandom_range(99) < 15) ? OP_DUMP : OP_INSERT, KEY_W'($urandom),
			$urandom, $urandom, $urandom, $urandom);
		if (r.op == OP_INSERT) begin
			n    = kept_count();
			pick = $urandom_range(99);
			if (pick < 10)
				s = '0;
			else if (pick < 15)
				s = '1;
			else if (pick < 30 || n == 0)
				s = $urandom;
			else if (pick < 50)
				s = $urandom_range(40);
			else begin
				s = score_tab[$urandom_range(n - 1)];
				case ($urandom_range(2))
					0: if (s != '0) s = s - 1'b1;
					2: if (s != '1) s = s + 1'b1;
					default: ;
				endcase
			end
			case (metric_now)
				MET_LOGINS: r.logins = s;
				MET_POSTS:  r.posts  = s;
				MET_STAY:   r.stay   = s;
				default:    r.merit  = s;
			endcase
		end
		return r;
	endfunction

	// random sender gaps, then hold the item until it is taken
	task automatic present(row_t r);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= r.op;
		key          <= r.key;
		logins       <= r.logins;
		posts        <= r.posts;
		stay_seconds <= r.stay;
		merit        <= r.merit;
		known_now    <= (r.kind == ROW_KNOWN_DUMP);
		known_key    <= r.top_key;
		known_score  <= r.top_score;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// let every expected result drain and the core go quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (listing_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int plan_entries [BLOCKS] = '{16, 1, -1, 31, 0, -1, 16, 2, -1};
		int send_plan [3] = '{11, 46, 0};
		int recv_plan [3] = '{46, 11, 0};
		int ent;

		arst_n       <= 1'b0;
		cfg_write    <= 1'b0;
		cfg_index    <= REG_METRIC;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		op           <= OP_INSERT;
		key          <= '0;
		logins       <= '0;
		posts        <= '0;
		stay_seconds <= '0;
		merit        <= '0;
		known_now    <= 1'b0;
		known_key    <= '0;
		known_score  <= '0;
		out_stall    <= 1'b0;
		fails        = 0;
		cycles       = 0;
		send_pct     = send_plan[0];
		recv_pct     = recv_plan[0];
		for (int i = 0; i < DEPTH; i++) begin
			score_tab[i] = '0;
			key_tab[i]   = '0;
		end
		metric_now = MET_LOGINS;
		places_now = ENTRIES_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty list, zero score refused, extremes, tie order, all metrics
		plan.push_back(known_dump('0, '0));
		plan.push_back(item_row(OP_INSERT, 16'h0001, '0, '1, '1, '1));
		plan.push_back(known_dump('0, '0));
		plan.push_back(item_row(OP_INSERT, 16'hFFFF, '1, '0, '0, '0));
		plan.push_back(known_dump(16'hFFFF, '1));
		plan.push_back(item_row(OP_INSERT, 16'h0002, '1, 32'd9, 32'd9, 32'd9));
		plan.push_back(item_row(OP_INSERT, 16'h0000, 32'd1, '0, '0, '0));
		plan.push_back(item_row(OP_INSERT, 16'h0003, 32'd5, '1, '1, '1));
		plan.push_back(reg_row(REG_METRIC, CFG_DAT_W'(MET_POSTS)));
		plan.push_back(item_row(OP_INSERT, 16'h0010, '0, 32'd7, '1, '1));
		plan.push_back(reg_row(REG_METRIC, CFG_DAT_W'(MET_STAY)));
		plan.push_back(item_row(OP_INSERT, 16'h0011, '1, '1, 32'd100, '0));
		plan.push_back(reg_row(REG_METRIC, CFG_DAT_W'(MET_MERIT)));
		plan.push_back(item_row(OP_INSERT, 16'h0012, '0, '0, '0, 32'h8000_0000));
		plan.push_back(item_row(OP_INSERT, 16'h0013, '1, '1, '1, 32'h8000_0000));
		plan.push_back(item_row(OP_DUMP, '1, '1, '1, '1, '1));
		// a single kept place: a lower score and an equal one both stay out
		plan.push_back(reg_row(REG_ENTRIES, CFG_DAT_W'(1)));
		plan.push_back(item_row(OP_INSERT, 16'h0020, '0, '0, '0, 32'd3));
		plan.push_back(item_row(OP_INSERT, 16'h0021, '0, '0, '0, '1));
		plan.push_back(item_row(OP_DUMP, '0, '0, '0, '0, '0));
		// no places kept: insert is dropped, dump yields nothing
		plan.push_back(reg_row(REG_ENTRIES, CFG_DAT_W'(0)));
		plan.push_back(item_row(OP_INSERT, 16'h0022, '1, '1, '1, '1));
		plan.push_back(item_row(OP_DUMP, '0, '0, '0, '0, '0));
		// count above depth acts as depth; the places past one kept their contents
		plan.push_back(reg_row(REG_ENTRIES, '1));
		plan.push_back(item_row(OP_DUMP, '0, '0, '0, '0, '0));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG)
				reg_write(plan[i].reg_idx, plan[i].reg_val);
			else
				present(plan[i]);
		end

		// random: three idling patterns, three register settings each
		for (int ph = 0; ph < 3; ph++) begin
			for (int b = 0; b < 3; b++) begin
				ent = plan_entries[ph * 3 + b];
				if (ent < 0)
					ent = $urandom_range(2, DEPTH - 1);
				reg_write(REG_METRIC, CFG_DAT_W'((ph * 3 + b) % 4));
				reg_write(REG_ENTRIES, CFG_DAT_W'(ent));
				send_pct = send_plan[ph];
				recv_pct = recv_plan[ph];
				repeat (BLOCK_ITEMS)
					present(draw_candidate());
			end
		end

		// wait out the last results, then a margin for anything stray
		in_valid <= 1'b0;
		@(posedge clk);
		while (listing_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fails == 0 && listing_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
rtl/tkri_pkg.sv
rtl/tkri_cell.sv
rtl/tkri_dump.sv
rtl/top_k_ranking_insert_core.sv
tb/top_k_ranking_insert_core_tb.sv
